FILE: src/sdts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdts_pkg
// Types and constants shared by the pipelined signed divider.
// ----------------------------------------------------------------------------
package sdts_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned MAG_W           = DATA_W + 1;
	localparam int unsigned STEPS_PER_STAGE = 3;
	localparam int unsigned NUM_DIV_STAGES  = MAG_W / STEPS_PER_STAGE;

	localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] dividend;
		logic signed [DATA_W-1:0] divisor;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quotient;
		logic                     saturated;
		logic                     divide_by_zero;
	} rsp_t;

	// Partial division state carried down the pipeline.
	// num shifts left each step; quotient bits enter at its low end.
	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [MAG_W-1:0] num;
		logic [MAG_W-1:0] den;
		logic             neg;
		logic             dbz;
	} work_t;

endpackage

FILE: src/sdts_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdts_prep
// Input stage: takes operand magnitudes at 33 bits and the quotient sign.
// ----------------------------------------------------------------------------
module sdts_prep import sdts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  req_t  in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output work_t out_data
);

	logic  valid_s1;
	work_t op_s1;
	work_t op_next;

	function automatic logic [MAG_W-1:0] mag33(input logic [DATA_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {v[DATA_W-1], v};
		return v[DATA_W-1] ? (MAG_W'(0) - ext) : ext;
	endfunction

	always_comb begin
		op_next.rem = '0;
		op_next.num = mag33(in_data.dividend);
		op_next.den = mag33(in_data.divisor);
		op_next.neg = in_data.dividend[DATA_W-1] ^ in_data.divisor[DATA_W-1];
		op_next.dbz = (in_data.divisor == '0);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = op_s1;

endmodule

FILE: src/sdts_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdts_div_stage
// One divider pipeline stage: a few restoring shift-and-subtract steps.
// ----------------------------------------------------------------------------
module sdts_div_stage import sdts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  work_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output work_t out_data
);

	logic  valid_s2;
	work_t work_s2;
	work_t work_next;

	always_comb begin
		logic [MAG_W-1:0] trial;
		logic [MAG_W:0]   diff;
		work_next = in_data;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			// bring the next dividend bit into the partial remainder
			trial = {work_next.rem[MAG_W-2:0], work_next.num[MAG_W-1]};
			diff  = {1'b0, trial} - {1'b0, work_next.den};
			if (!diff[MAG_W]) begin
				work_next.rem = diff[MAG_W-1:0];
			end else begin
				work_next.rem = trial;
			end
			work_next.num = {work_next.num[MAG_W-2:0], !diff[MAG_W]};
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			work_s2 <= work_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = work_s2;

endmodule

FILE: src/sdts_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdts_post
// Output stage: applies the sign, saturates, flags a zero divisor.
// ----------------------------------------------------------------------------
module sdts_post import sdts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  work_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output rsp_t  out_data
);

	logic valid_s3;
	rsp_t rsp_s3;
	rsp_t rsp_next;
	logic over;

	// a positive quotient above the 32-bit limit has bit 32 or bit 31 set
	assign over = !in_data.neg && (in_data.num[MAG_W-1] || in_data.num[DATA_W-1]);

	always_comb begin
		rsp_next.saturated      = 1'b0;
		rsp_next.divide_by_zero = 1'b0;
		if (in_data.dbz) begin
			rsp_next.quotient       = '0;
			rsp_next.divide_by_zero = 1'b1;
		end else if (over) begin
			rsp_next.quotient  = POS_LIMIT;
			rsp_next.saturated = 1'b1;
		end else if (in_data.neg) begin
			rsp_next.quotient = DATA_W'(0) - in_data.num[DATA_W-1:0];
		end else begin
			rsp_next.quotient = in_data.num[DATA_W-1:0];
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rsp_s3 <= rsp_next;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = rsp_s3;

endmodule

FILE: src/signed_divide_truncate_saturate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_divide_truncate_saturate
// Pipelined 32-bit signed divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one dividend/divisor pair per item; the rsp
//   channel returns one quotient item per request, in order.
//   An accepted item passes one operand stage, 11 divide stages of 3
//   restoring steps each (33 steps over the 33-bit magnitudes) and one
//   output stage before rsp_valid.
//   Throughput is one item per cycle while rsp_ready is high; each stage
//   holds its own item and the divide stages each own a subtractor chain.
//   -2^31 / -1 returns 0x7FFFFFFF with saturated set. A zero divisor
//   returns 0 with divide_by_zero set.
//   Reset clears every stage's valid bit; items in flight are dropped.
//   When rsp_ready is low the pipeline fills behind the output register
//   and req_ready drops once every stage holds an item; nothing is lost.
// ----------------------------------------------------------------------------
module signed_divide_truncate_saturate import sdts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic  vld   [NUM_DIV_STAGES+1];
	logic  rdy   [NUM_DIV_STAGES+1];
	work_t work  [NUM_DIV_STAGES+1];

	sdts_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.in_data   (req),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_data  (work[0])
	);

	for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
		sdts_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[g]),
			.in_ready  (rdy[g]),
			.in_data   (work[g]),
			.out_valid (vld[g+1]),
			.out_ready (rdy[g+1]),
			.out_data  (work[g+1])
		);
	end

	sdts_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[NUM_DIV_STAGES]),
		.in_ready  (rdy[NUM_DIV_STAGES]),
		.in_data   (work[NUM_DIV_STAGES]),
		.out_valid (rsp_valid),
		.out_ready (rsp_ready),
		.out_data  (rsp)
	);

endmodule

FILE: src/sdts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdts_checker
// Port-level checks for the signed divider, bound to the top level.
// ----------------------------------------------------------------------------
module sdts_checker import sdts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// zero divisor result carries a zero quotient and no saturation
	a_dbz_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.divide_by_zero |-> rsp.quotient == '0 && !rsp.saturated)
		else $error("divide_by_zero item with nonzero quotient or saturation");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.saturated |-> rsp.quotient == POS_LIMIT)
		else $error("saturated item without the positive limit");

	// an empty pipeline must be able to take an item
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid && $past(!rsp_valid) && $past(!req_valid) |-> req_ready)
		else $error("req_ready low while pipeline drained");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp item changed or dropped while stalled");

endmodule

bind signed_divide_truncate_saturate sdts_checker u_sdts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pipelined signed divider: directed corner
// pairs, then shaped random pairs, with bursty requests and a stalling
// response side. Each response is checked against a behavioral quotient.
// ----------------------------------------------------------------------------
module tb;
	import sdts_pkg::*;

	localparam logic signed [DATA_W-1:0] MIN_INT   = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MAX_INT   = POS_LIMIT;
	localparam int unsigned              N_RANDOM  = 1525;
	localparam int unsigned              DRAIN_CYC = 40;
	localparam longint unsigned          CYC_LIMIT = 600000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	req_t pending_q[$];
	rsp_t quot_due_q[$];

	int unsigned     total_items = 0;
	int unsigned     sent_cnt    = 0;
	int unsigned     burst_left  = 0;
	int unsigned     gap_left    = 0;
	int unsigned     err_cnt     = 0;
	int unsigned     stall_mode  = 0;
	int unsigned     stall_per   = 2;
	int unsigned     pattern_cnt = 0;
	longint unsigned cycle_cnt   = 0;

	signed_divide_truncate_saturate i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Truncating signed divide on 33-bit magnitudes, clamped on overflow.
	function automatic rsp_t signed_divide(req_t r);
		logic [MAG_W-1:0] ext_a;
		logic [MAG_W-1:0] ext_b;
		logic [MAG_W-1:0] mag_a;
		logic [MAG_W-1:0] mag_b;
		logic [MAG_W-1:0] mag_q;
		logic [MAG_W-1:0] neg_q;
		logic             neg;
		rsp_t             res;
		res = '0;
		if (r.divisor == '0) begin
			res.divide_by_zero = 1'b1;
			return res;
		end
		ext_a = {r.dividend[DATA_W-1], r.dividend};
		ext_b = {r.divisor[DATA_W-1], r.divisor};
		mag_a = r.dividend[DATA_W-1] ? (~ext_a + 1'b1) : ext_a;
		mag_b = r.divisor[DATA_W-1] ? (~ext_b + 1'b1) : ext_b;
		mag_q = mag_a / mag_b;
		neg   = r.dividend[DATA_W-1] ^ r.divisor[DATA_W-1];
		neg_q = ~mag_q + 1'b1;
		if (!neg && mag_q > {1'b0, POS_LIMIT}) begin
			res.quotient  = POS_LIMIT;
			res.saturated = 1'b1;
		end else begin
			res.quotient = neg ? neg_q[DATA_W-1:0] : mag_q[DATA_W-1:0];
		end
		return res;
	endfunction

	function automatic logic signed [DATA_W-1:0] shaped_operand();
		logic signed [DATA_W-1:0] v;
		v = $urandom >> $urandom_range(0, DATA_W - 1);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	function automatic logic signed [DATA_W-1:0] small_operand(int unsigned lim);
		logic signed [DATA_W-1:0] v;
		v = $urandom_range(1, lim);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic add_pair(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
		req_t r;
		r.dividend = a;
		r.divisor  = b;
		pending_q.push_back(r);
	endtask

	// Request side: bursts of items separated by random gaps.
	always @(posedge clk) begin : drive_blk
		logic slot_free;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				quot_due_q.push_back(signed_divide(req));
				sent_cnt++;
			end
			slot_free = !req_valid || req_ready;
			if (slot_free) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					req       <= pending_q.pop_front();
					req_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response side: check each item, then pick ready from the stall pattern.
	always @(posedge clk) begin : check_blk
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (quot_due_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: unexpected item q=%0d sat=%0b dbz=%0b", $realtime,
							rsp.quotient, rsp.saturated, rsp.divide_by_zero);
				end else begin
					want = quot_due_q.pop_front();
					if (rsp.quotient !== want.quotient || rsp.saturated !== want.saturated
						|| rsp.divide_by_zero !== want.divide_by_zero) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("%0t: mismatch exp q=%0d sat=%0b dbz=%0b, got q=%0d sat=%0b dbz=%0b",
								$realtime, want.quotient, want.saturated, want.divide_by_zero,
								rsp.quotient, rsp.saturated, rsp.divide_by_zero);
					end
				end
			end
			pattern_cnt++;
			if (pattern_cnt % 100 == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_per  = $urandom_range(2, 6);
			end
			case (stall_mode)
				0:       rsp_ready <= 1'b1;
				1:       rsp_ready <= 1'($urandom_range(0, 1));
				2:       rsp_ready <= (pattern_cnt % stall_per == 0);
				default: rsp_ready <= (pattern_cnt % 32 >= 24);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYC_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stim_blk
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;

		// zero divisor, whatever the dividend
		add_pair(0, 0);
		add_pair(5, 0);
		add_pair(MIN_INT, 0);
		add_pair(MAX_INT, 0);
		// the one overflow, and its neighbors
		add_pair(MIN_INT, -1);
		add_pair(MIN_INT, 1);
		add_pair(MIN_INT, 2);
		add_pair(MIN_INT, MIN_INT);
		add_pair(MIN_INT, MAX_INT);
		add_pair(MAX_INT, MIN_INT);
		add_pair(MAX_INT, MAX_INT);
		add_pair(MAX_INT, 1);
		add_pair(MAX_INT, -1);
		add_pair(1, MIN_INT);
		// truncation toward zero in every sign combination
		add_pair(7, 2);
		add_pair(-7, 2);
		add_pair(7, -2);
		add_pair(-7, -2);
		add_pair(1, MAX_INT);
		add_pair(-1, 1);
		add_pair(-1, -1);
		add_pair(0, -1);
		add_pair(100, 7);
		add_pair(12345678, -3);
		add_pair(-32'sd1, 32'sh7FFF_FFFE);

		for (int unsigned i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					a = $urandom;
					b = $urandom;
				end
				4: begin
					a = $urandom;
					b = small_operand(16);
				end
				5: begin
					a = shaped_operand();
					b = shaped_operand();
				end
				6: begin
					a = ($urandom_range(0, 1)) ? shaped_operand() : $urandom;
					b = '0;
				end
				7: begin
					a = MIN_INT;
					b = ($urandom_range(0, 2) == 0) ? -1 : small_operand(4);
				end
				8: begin
					a = small_operand(64);
					b = $urandom;
				end
				default: begin
					// exact multiples: quotient lands on a clean boundary
					b = small_operand(4096);
					a = b * small_operand(65536);
				end
			endcase
			if (b == '0 && $urandom_range(0, 3) != 0)
				b = 1;
			add_pair(a, b);
		end
		total_items = pending_q.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_cnt < total_items)
			@(posedge clk);
		while (quot_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
